// File: design/prq_pkg.sv
// Shared types, constants and helpers of the strict priority port queue.
// Used by prq_sched and strict_priority_port_queue; depends on nothing.
`default_nettype none

package prq_pkg;

  // Sizing
  localparam int NUM_CLASSES  = 8;
  localparam int QUEUE_DEPTH  = 256;
  localparam int HANDLE_WIDTH = 16;

  localparam int CLASS_W   = $clog2(NUM_CLASSES);
  localparam int PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int RAM_DEPTH = NUM_CLASSES * (2 ** PTR_W);

  // Fixed field widths
  localparam int OP_W           = 2;
  localparam int PORT_W         = 16;
  localparam int HANDLE_FIELD_W = 16;
  localparam int CLASS_FIELD_W  = 3;
  localparam int LIMIT_W        = 9;

  // Operation codes
  localparam logic [OP_W-1:0] OP_ENQ    = 2'd0;
  localparam logic [OP_W-1:0] OP_DEQ    = 2'd1;
  localparam logic [OP_W-1:0] OP_PEEK   = 2'd2;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd3;

  // Register indexes and reset values
  localparam logic REG_BASE_PORT   = 1'b0;
  localparam logic REG_CLASS_LIMIT = 1'b1;
  localparam logic [PORT_W-1:0]  RESET_BASE_PORT   = 16'd9;
  localparam logic [LIMIT_W-1:0] RESET_CLASS_LIMIT = 9'd256;

  typedef struct packed {
    logic [PORT_W-1:0]  base_port;
    logic [LIMIT_W-1:0] class_limit;
  } cfg_t;

  typedef struct packed {
    logic                      ok;
    logic [HANDLE_FIELD_W-1:0] handle;
    logic [CLASS_FIELD_W-1:0]  cls;
  } result_t;

  // Ring pointer advance with wrap at the queue depth
  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] n;
    n = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
    return n;
  endfunction

endpackage

`default_nettype wire

// File: design/strict_priority_port_queue.sv
// Top level of the strict priority port queue: APB register file, handle RAM
// and scheduler core. Uses prq_pkg, prq_ram and prq_sched.
//
//   channel   dir  handshake                  payload
//   s_axis    in   s_axis_tvalid/tready       tuser: op; tdata: dest_port, packet_handle
//   m_axis    out  m_axis_tvalid/tready       tuser: ok; tdata: out_handle, out_class
//   apb       in   psel/penable, pready = 1   base_port @0x0, class_limit @0x4
//
// An enqueue loads its result from the execute step; a dequeue, peek or remove
// that finds a packet loads it from a response step, as the RAM read is registered.
// A result waits in the output register; while it stalls, the next item is
// accepted and held in the execute step until the register frees up.
// Reset (rst, synchronous) empties every class by clearing pointers and
// fill counts; RAM contents are never read before written, so need no clear.
`default_nettype none

module strict_priority_port_queue (
  input  wire logic        clk,
  input  wire logic        rst,
  // input beats
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [15:0] dest_port, [31:16] packet_handle
  input  wire logic [1:0]  s_axis_tuser,   // [1:0] op
  // result beats
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [15:0] out_handle, [18:16] out_class, rest 0
  output logic [0:0]       m_axis_tuser,   // [0] ok
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  prq_pkg::cfg_t    cfg;
  prq_pkg::result_t res;

  logic                                        ram_en;
  logic                                        ram_we;
  logic [prq_pkg::CLASS_W+prq_pkg::PTR_W-1:0]  ram_addr;
  logic [prq_pkg::HANDLE_WIDTH-1:0]            ram_wdata;
  logic [prq_pkg::HANDLE_WIDTH-1:0]            ram_rdata;
  logic                                        reg_sel;

  // Registers decode on the word address bit; no wait states
  assign pready  = 1'b1;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_port   <= prq_pkg::RESET_BASE_PORT;
      cfg.class_limit <= prq_pkg::RESET_CLASS_LIMIT;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_sel)
        prq_pkg::REG_BASE_PORT:   cfg.base_port   <= pwdata[prq_pkg::PORT_W-1:0];
        prq_pkg::REG_CLASS_LIMIT: cfg.class_limit <= pwdata[prq_pkg::LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      prq_pkg::REG_BASE_PORT:   prdata = 32'(cfg.base_port);
      prq_pkg::REG_CLASS_LIMIT: prdata = 32'(cfg.class_limit);
      default:                  prdata = '0;
    endcase
  end

  // Handle store: one ring of QUEUE_DEPTH slots per class, indexed {class, slot}
  prq_ram #(
    .WIDTH (prq_pkg::HANDLE_WIDTH),
    .DEPTH (prq_pkg::RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  prq_sched u_sched (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_op     (s_axis_tuser),
    .in_port   (s_axis_tdata[15:0]),
    .in_handle (s_axis_tdata[31:16]),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (res),
    .ram_en    (ram_en),
    .ram_we    (ram_we),
    .ram_addr  (ram_addr),
    .ram_wdata (ram_wdata),
    .ram_rdata (ram_rdata)
  );

  // Pack the result beat, zero fill to the byte boundary
  assign m_axis_tdata = {5'b0, res.cls, res.handle};
  assign m_axis_tuser = res.ok;

endmodule

`default_nettype wire

// File: design/prq_ram.sv
// Generic single-port synchronous RAM with a registered read.
// Stand-alone; no package needed.
`default_nettype none

module prq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

`default_nettype wire

// File: design/prq_sched.sv
// Scheduler core: per-class ring pointers and fill counts, class select,
// sequencer and output register. Uses prq_pkg; drives the handle RAM port.
`default_nettype none

module prq_sched (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire prq_pkg::cfg_t                     cfg,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [prq_pkg::OP_W-1:0]          in_op,
  input  wire logic [prq_pkg::PORT_W-1:0]        in_port,
  input  wire logic [prq_pkg::HANDLE_FIELD_W-1:0] in_handle,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output prq_pkg::result_t                       out_res,
  output logic                                   ram_en,
  output logic                                   ram_we,
  output logic [prq_pkg::CLASS_W+prq_pkg::PTR_W-1:0] ram_addr,
  output logic [prq_pkg::HANDLE_WIDTH-1:0]       ram_wdata,
  input  wire logic [prq_pkg::HANDLE_WIDTH-1:0]  ram_rdata
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_RESP = 2'd2;

  logic [1:0] state;

  logic [prq_pkg::OP_W-1:0]           op_q;
  logic [prq_pkg::PORT_W-1:0]         port_q;
  logic [prq_pkg::HANDLE_FIELD_W-1:0] handle_q;
  logic [prq_pkg::CLASS_W-1:0]        served_cls;

  logic [prq_pkg::PTR_W-1:0] head [prq_pkg::NUM_CLASSES];
  logic [prq_pkg::PTR_W-1:0] tail [prq_pkg::NUM_CLASSES];
  logic [prq_pkg::CNT_W-1:0] fill [prq_pkg::NUM_CLASSES];

  logic [prq_pkg::PORT_W:0]    diff;
  logic [prq_pkg::CLASS_W-1:0] enq_cls;
  logic [prq_pkg::CLASS_W-1:0] top_cls;
  logic [prq_pkg::CNT_W-1:0]   limit;
  logic                        found;
  logic                        enq_ok;
  logic                        is_enq;
  logic                        out_free;
  logic                        go;
  logic                        load_out;

  assign in_ready = (state == ST_IDLE);
  assign is_enq   = (op_q == prq_pkg::OP_ENQ);
  assign out_free = !out_valid || out_ready;
  assign go       = (state == ST_EXEC) && out_free;
  // Read results land in RESP; everything else loads straight from EXEC
  assign load_out = (go && (is_enq || !found)) || (state == ST_RESP);

  always_comb begin
    diff = {1'b0, port_q} - {1'b0, cfg.base_port};
    if (diff[prq_pkg::PORT_W]) begin
      enq_cls = '0;
    end else if (diff[prq_pkg::PORT_W-1:0] > prq_pkg::PORT_W'(prq_pkg::NUM_CLASSES - 1)) begin
      enq_cls = prq_pkg::CLASS_W'(prq_pkg::NUM_CLASSES - 1);
    end else begin
      enq_cls = diff[prq_pkg::CLASS_W-1:0];
    end

    if (32'(cfg.class_limit) > 32'(prq_pkg::QUEUE_DEPTH)) begin
      limit = prq_pkg::CNT_W'(prq_pkg::QUEUE_DEPTH);
    end else begin
      limit = prq_pkg::CNT_W'(cfg.class_limit);
    end
    enq_ok = (fill[enq_cls] < limit);

    // Highest non-empty class wins
    top_cls = '0;
    found   = 1'b0;
    for (int c = 0; c < prq_pkg::NUM_CLASSES; c++) begin
      if (fill[c] != '0) begin
        top_cls = prq_pkg::CLASS_W'(c);
        found   = 1'b1;
      end
    end
  end

  assign ram_en    = go && (is_enq ? enq_ok : found);
  assign ram_we    = is_enq;
  assign ram_addr  = is_enq ? {enq_cls, tail[enq_cls]} : {top_cls, head[top_cls]};
  assign ram_wdata = prq_pkg::HANDLE_WIDTH'(handle_q);

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      for (int c = 0; c < prq_pkg::NUM_CLASSES; c++) begin
        head[c] <= '0;
        tail[c] <= '0;
        fill[c] <= '0;
      end
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (out_free) begin
            state <= (!is_enq && found) ? ST_RESP : ST_IDLE;
          end
        end
        ST_RESP: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      for (int c = 0; c < prq_pkg::NUM_CLASSES; c++) begin
        if (go && is_enq && enq_ok && (enq_cls == prq_pkg::CLASS_W'(c))) begin
          tail[c] <= prq_pkg::next_slot(tail[c]);
          fill[c] <= prq_pkg::CNT_W'(fill[c] + 1'b1);
        end
        if (go && !is_enq && found && (op_q != prq_pkg::OP_PEEK) &&
            (top_cls == prq_pkg::CLASS_W'(c))) begin
          head[c] <= prq_pkg::next_slot(head[c]);
          fill[c] <= prq_pkg::CNT_W'(fill[c] - 1'b1);
        end
      end

      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_q     <= in_op;
      port_q   <= in_port;
      handle_q <= in_handle;
    end
    if (go) begin
      served_cls <= top_cls;
    end
    if (state == ST_RESP) begin
      out_res.ok     <= 1'b1;
      out_res.handle <= prq_pkg::HANDLE_FIELD_W'(ram_rdata);
      out_res.cls    <= prq_pkg::CLASS_FIELD_W'(served_cls);
    end else if (go && is_enq) begin
      out_res.ok     <= enq_ok;
      out_res.handle <= '0;
      out_res.cls    <= prq_pkg::CLASS_FIELD_W'(enq_cls);
    end else if (go && !found) begin
      out_res <= '0;
    end
  end

  // Checks
  a_enq_count: assert property (@(posedge clk) disable iff (rst)
    (go && is_enq && enq_ok) |=>
      (fill[$past(enq_cls)] == prq_pkg::CNT_W'($past(fill[enq_cls]) + 1'b1)))
    else $error("fill count did not advance on accepted enqueue");

  a_resp_slot: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RESP) |-> !out_valid)
    else $error("output register busy when read data arrives");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_res.ok) |-> (out_res.handle == '0))
    else $error("refused or empty result carries a handle");

  for (genvar g = 0; g < prq_pkg::NUM_CLASSES; g++) begin : g_chk
    a_ring: assert property (@(posedge clk) disable iff (rst)
      (fill[g] <= prq_pkg::CNT_W'(prq_pkg::QUEUE_DEPTH)) &&
      ((fill[g] == '0) -> (head[g] == tail[g])))
      else $error("class ring pointers and fill count disagree");
  end

endmodule

`default_nettype wire
